// File: rtl/core/fir_convolution_filter_core_assert.svh
// assertion macros used by the filter checker
`ifndef FIR_CONVOLUTION_FILTER_CORE_ASSERT_SVH
`define FIR_CONVOLUTION_FILTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fcf_pkg.sv
`default_nettype none

package fcf_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 9;

	// item commands
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic [DATA_W-1:0] word_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_CLEAR,
		ST_REPLAY
	} state_t;

	// control broadcast to the head and every cell
	typedef struct packed {
		logic             step;
		logic             clr;
		logic             load;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/fir_convolution_filter_core.sv
// a result is registered at the sample transfer that causes it and shown in the next cycle
// throughput: one item per cycle unless req_stall is raised by a held output or a rebuild
// a sample that follows tap loads made after samples began is stalled first, while the chain
// rebuilds its partial sums from the stored window: detect, then clear, then replay of the
// window through the cells
// reset: window, partial sums, fill count and output valid clear at once; taps stay
// undefined until loaded
`default_nettype none

module fir_convolution_filter_core #(
	parameter int TAPS = 257
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic                       cmd,
	input  wire logic [fcf_pkg::IDX_W-1:0]  tap_index,
	input  wire logic signed [fcf_pkg::DATA_W-1:0] value,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic signed [fcf_pkg::DATA_W-1:0] filtered
);

	localparam int CELLS  = (TAPS > 1) ? TAPS - 1 : 1;
	localparam int HALF   = (TAPS - 1) / 2;
	localparam int FILL_W = (HALF > 0) ? $clog2(HALF + 1) : 1;
	localparam int CNT_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

	fcf_pkg::state_t state_q;
	fcf_pkg::state_t state_d;
	fcf_pkg::ctrl_t  ctrl;
	fcf_pkg::word_t  x_feed;
	fcf_pkg::word_t  head_p;
	fcf_pkg::word_t  filtered_w;
	fcf_pkg::word_t  win_chain [0:CELLS];
	fcf_pkg::word_t  p_chain   [1:CELLS+1];

	logic              dirty_q;
	logic              seen_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              is_sample;
	logic              out_block;
	logic              fill_full;
	logic              replay_done;
	logic              accept;

	assign is_sample   = (cmd == fcf_pkg::CMD_SAMPLE);
	assign out_block   = rsp_valid & rsp_stall;
	assign fill_full   = (fill_q == FILL_W'(HALF));
	assign replay_done = (state_q == fcf_pkg::ST_REPLAY) && (cnt_q == CNT_W'(CELLS - 1));

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		ctrl.idx  = tap_index;
		req_stall = 1'b1;
		accept    = 1'b0;
		x_feed    = fcf_pkg::word_t'(value);
		case (state_q)
			fcf_pkg::ST_RUN: begin
				req_stall = out_block | (is_sample & dirty_q);
				accept    = req_valid & ~req_stall;
				ctrl.load = accept & ~is_sample;
				ctrl.step = accept & is_sample;
				ctrl.emit = accept & is_sample & fill_full;
				if (req_valid && is_sample && dirty_q) begin
					state_d = fcf_pkg::ST_CLEAR;
				end
			end
			fcf_pkg::ST_CLEAR: begin
				ctrl.clr = 1'b1;
				state_d  = fcf_pkg::ST_REPLAY;
			end
			fcf_pkg::ST_REPLAY: begin
				ctrl.step = 1'b1;
				x_feed    = win_chain[CELLS];
				if (replay_done) begin
					state_d = fcf_pkg::ST_RUN;
				end
			end
			default: begin
				state_d = fcf_pkg::ST_RUN;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcf_pkg::ST_RUN;
			dirty_q <= 1'b0;
			seen_q  <= 1'b0;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fcf_pkg::ST_CLEAR) begin
				cnt_q <= '0;
			end else if (state_q == fcf_pkg::ST_REPLAY) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctrl.load && seen_q && (TAPS > 1)) begin
				dirty_q <= 1'b1;
			end else if (replay_done) begin
				dirty_q <= 1'b0;
			end
			if (accept && is_sample) begin
				seen_q <= 1'b1;
				if (!fill_full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// tap cell chain: samples move away from the head, partial sums towards it
	assign win_chain[0]     = x_feed;
	assign p_chain[CELLS+1] = '0;

	for (genvar c = 1; c <= CELLS; c++) begin : g_cell
		fcf_cell #(
			.TAP_POS (TAPS - 1 - c)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load_val (fcf_pkg::word_t'(value)),
			.x_in     (x_feed),
			.win_in   (win_chain[c-1]),
			.win_out  (win_chain[c]),
			.p_in     (p_chain[c+1]),
			.p_out    (p_chain[c])
		);
	end

	// a single tap has no chain behind the head
	assign head_p = (TAPS > 1) ? p_chain[1] : '0;

	fcf_head #(
		.TAP_POS (TAPS - 1)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_val  (fcf_pkg::word_t'(value)),
		.x_in      (x_feed),
		.p_in      (head_p),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.filtered  (filtered_w)
	);

	assign filtered = filtered_w;

endmodule

`default_nettype wire

// File: rtl/core/fcf_cell.sv
`default_nettype none

module fcf_cell #(
	parameter int TAP_POS = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fcf_pkg::ctrl_t ctrl,
	input  wire fcf_pkg::word_t load_val,
	input  wire fcf_pkg::word_t x_in,
	input  wire fcf_pkg::word_t win_in,
	input  wire fcf_pkg::word_t p_in,
	output fcf_pkg::word_t      win_out,
	output fcf_pkg::word_t      p_out
);

	fcf_pkg::word_t tap_q;
	fcf_pkg::word_t win_q;
	fcf_pkg::word_t p_q;
	fcf_pkg::word_t prod;
	logic           hit;

	// coefficient held by this cell
	assign hit = ctrl.load && (int'(ctrl.idx) == TAP_POS);

	always_ff @(posedge clk) begin
		if (hit) begin
			tap_q <= load_val;
		end
	end

	// wrapping product of the broadcast sample and this tap
	assign prod = tap_q * x_in;

	// delay line entry and transposed partial sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			p_q   <= '0;
		end else begin
			if (ctrl.step) begin
				win_q <= win_in;
			end
			if (ctrl.clr) begin
				p_q <= '0;
			end else if (ctrl.step) begin
				p_q <= prod + p_in;
			end
		end
	end

	assign win_out = win_q;
	assign p_out   = p_q;

endmodule

`default_nettype wire

// File: rtl/core/fcf_head.sv
`default_nettype none

module fcf_head #(
	parameter int TAP_POS = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fcf_pkg::ctrl_t ctrl,
	input  wire fcf_pkg::word_t load_val,
	input  wire fcf_pkg::word_t x_in,
	input  wire fcf_pkg::word_t p_in,
	input  wire logic           rsp_stall,
	output logic                rsp_valid,
	output fcf_pkg::word_t      filtered
);

	fcf_pkg::word_t tap_q;
	fcf_pkg::word_t filtered_q;
	fcf_pkg::word_t sum;
	logic           valid_q;

	// newest-sample coefficient
	always_ff @(posedge clk) begin
		if (ctrl.load && (int'(ctrl.idx) == TAP_POS)) begin
			tap_q <= load_val;
		end
	end

	// final product plus the sum handed down the chain
	assign sum = (tap_q * x_in) + p_in;

	// output register
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			filtered_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign rsp_valid = valid_q;
	assign filtered  = filtered_q;

endmodule

`default_nettype wire

// File: rtl/core/fcf_checker.sv
`default_nettype none

`include "fir_convolution_filter_core_assert.svh"

module fcf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_stall,
	input wire logic                          cmd,
	input wire logic [fcf_pkg::IDX_W-1:0]     tap_index,
	input wire logic signed [fcf_pkg::DATA_W-1:0] value,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic signed [fcf_pkg::DATA_W-1:0] filtered
);

	logic                                    req_xfer;
	logic                                    rsp_held;
	logic                                    req_held;
	logic                                    sample_xfer;
	logic [fcf_pkg::DATA_W+fcf_pkg::IDX_W:0] req_word;

	assign req_xfer    = req_valid && !req_stall;
	assign rsp_held    = rsp_valid && rsp_stall;
	assign req_held    = req_valid && req_stall;
	assign sample_xfer = req_xfer && (cmd == fcf_pkg::CMD_SAMPLE);
	assign req_word    = {cmd, tap_index, value};

	// a stalled result stays offered and unchanged
	`FCF_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid, "stalled result dropped")
	`FCF_ASSERT_NEXT(a_rsp_stable, rsp_held, $stable(filtered), "stalled result changed")

	// a new result only follows a sample transfer
	`FCF_ASSERT_NEXT(a_rsp_from_sample, !sample_xfer && !rsp_held, !rsp_valid, "result without sample")

	// a stalled request stays offered and unchanged
	`FCF_ASSERT_NEXT(a_req_hold, req_held, req_valid && $stable(req_word), "stalled request changed")

	// no transfer is taken while the output slot is held
	`FCF_ASSERT_NOW(a_back_pressure, rsp_held, req_stall, "input taken with output full")

endmodule

bind fir_convolution_filter_core fcf_checker u_fcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.cmd       (cmd),
	.tap_index (tap_index),
	.value     (value),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.filtered  (filtered)
);

`default_nettype wire

// File: tb/tb_fir_convolution_filter_core.sv
`timescale 1ns / 100ps

module tb_fir_convolution_filter_core;

	localparam int TAPS         = 257;
	localparam int HALF         = (TAPS - 1) / 2;
	localparam int RANDOM_ITEMS = 240;
	localparam int QUIET_TAIL   = 60;
	localparam int CYCLE_LIMIT  = 200000;

	// one row of the directed stimulus table
	typedef struct packed {
		logic                      op;
		logic [fcf_pkg::IDX_W-1:0] idx;
		fcf_pkg::word_t            val;
		logic                      typed;
		fcf_pkg::word_t            want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic                    cmd = fcf_pkg::CMD_LOAD;
	logic [fcf_pkg::IDX_W-1:0] tap_index = '0;
	logic signed [fcf_pkg::DATA_W-1:0] value = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic signed [fcf_pkg::DATA_W-1:0] filtered;

	// sideband travelling with the current request: a typed-in expectation
	logic           row_typed = 1'b0;
	fcf_pkg::word_t row_want = '0;

	// predictor state
	fcf_pkg::word_t coeffs [TAPS];
	fcf_pkg::word_t history [TAPS-1];
	int             fill = 0;

	fcf_pkg::word_t expected_filtered [$];
	stim_row_t      directed_rows [$];
	int             mismatches = 0;
	int             cycles = 0;
	int             idle_odds = 0;
	int             stall_left = 0;
	fcf_pkg::word_t front_sum;
	logic           pred_emits;
	fcf_pkg::word_t pred_sum;

	fir_convolution_filter_core #(
		.TAPS(TAPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.tap_index(tap_index),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.filtered(filtered)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// a load stores its tap; a sample forms the windowed sum of products, then shifts the delay line
	task automatic convolve_request(input logic op, input logic [fcf_pkg::IDX_W-1:0] idx,
		input fcf_pkg::word_t val, output logic emits, output fcf_pkg::word_t sum);
		fcf_pkg::word_t acc;
		acc = '0;
		emits = 1'b0;
		if (op == fcf_pkg::CMD_LOAD) begin
			if (idx < TAPS)
				coeffs[idx] = val;
		end else begin
			acc = val * coeffs[TAPS-1];
			for (int j = 0; j < TAPS - 1; j++)
				acc = acc + history[j] * coeffs[j];
			for (int j = 0; j < TAPS - 2; j++)
				history[j] = history[j+1];
			if (TAPS > 1)
				history[TAPS-2] = val;
			if (fill >= HALF)
				emits = 1'b1;
			else
				fill = fill + 1;
		end
		sum = acc;
	endtask

	task automatic add_row(input logic op, input logic [fcf_pkg::IDX_W-1:0] idx,
		input fcf_pkg::word_t val, input logic typed, input fcf_pkg::word_t want);
		stim_row_t r;
		r.op = op;
		r.idx = idx;
		r.val = val;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	// mostly random words, with the extremes mixed in
	function automatic fcf_pkg::word_t pick_value();
		case ($urandom_range(0, 15))
			0: pick_value = 32'h0000_0000;
			1: pick_value = 32'h0000_0001;
			2: pick_value = 32'hFFFF_FFFF;
			3: pick_value = 32'h8000_0000;
			4: pick_value = 32'h7FFF_FFFF;
			default: pick_value = $urandom;
		endcase
	endfunction

	// after an optional idle gap, present one request from a falling edge and hold it until the transfer
	task automatic send_item(input logic op, input logic [fcf_pkg::IDX_W-1:0] idx,
		input fcf_pkg::word_t val, input logic typed, input fcf_pkg::word_t want);
		int gap;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 6);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		cmd       <= op;
		tap_index <= idx;
		value     <= val;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// result-side stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// request transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			convolve_request(cmd, tap_index, value, pred_emits, pred_sum);
			if (pred_emits)
				expected_filtered.push_back(row_typed ? row_want : pred_sum);
		end
	end

	// result transfers checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_filtered.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: filtered=%h", filtered);
				mismatches <= mismatches + 1;
			end else begin
				front_sum = expected_filtered.pop_front();
				if (filtered !== front_sum) begin
					if (mismatches < 10)
						$display("filtered mismatch: expected=%h actual=%h", front_sum, filtered);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int                        k;
		int                        pick;
		logic                      op;
		logic [fcf_pkg::IDX_W-1:0] idx;

		for (k = 0; k < TAPS; k++)
			coeffs[k] = '0;
		for (k = 0; k < TAPS - 1; k++)
			history[k] = '0;

		// directed table, walked after zero taps and warm-up
		// all taps zero: nothing but zero comes out
		add_row(fcf_pkg::CMD_SAMPLE, 9'h000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h1FF, 32'h8000_0000, 1'b1, 32'h0000_0000);
		// only the newest-sample tap set, loaded mid-stream
		add_row(fcf_pkg::CMD_LOAD,   9'd256, 32'h0000_0001, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h0AA, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h155, 32'h8000_0000, 1'b1, 32'h8000_0000);
		// loads past the last tap are dropped
		add_row(fcf_pkg::CMD_LOAD,   9'd257, 32'h1234_5678, 1'b0, '0);
		add_row(fcf_pkg::CMD_LOAD,   9'h1FF, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h000, 32'h0000_0005, 1'b1, 32'h0000_0005);
		// negative tap and wrap of the product
		add_row(fcf_pkg::CMD_LOAD,   9'd256, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h0FF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h100, 32'h8000_0000, 1'b1, 32'h8000_0000);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h001, 32'h0000_0000, 1'b1, 32'h0000_0000);
		add_row(fcf_pkg::CMD_LOAD,   9'd256, 32'h8000_0000, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h080, 32'h8000_0000, 1'b1, 32'h0000_0000);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h07F, 32'h0000_0003, 1'b1, 32'h8000_0000);
		// oldest and centre taps at the extremes
		add_row(fcf_pkg::CMD_LOAD,   9'd0,   32'h7FFF_FFFF, 1'b0, '0);
		add_row(fcf_pkg::CMD_LOAD,   9'd128, 32'h8000_0000, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h1FF, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h000, 32'h0000_0001, 1'b0, '0);
		add_row(fcf_pkg::CMD_LOAD,   9'd256, 32'h0000_0000, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h1FF, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(fcf_pkg::CMD_SAMPLE, 9'h000, 32'h8000_0000, 1'b0, '0);

		// reset, once
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_odds = 4;

		// every tap defined before any sample
		for (k = 0; k < TAPS; k++)
			send_item(fcf_pkg::CMD_LOAD, k[fcf_pkg::IDX_W-1:0], '0, 1'b0, '0);

		// warm-up: window fills, no results
		for (k = 0; k < HALF; k++) begin
			pick = $urandom_range(0, 511);
			send_item(fcf_pkg::CMD_SAMPLE, pick[fcf_pkg::IDX_W-1:0], $urandom, 1'b0, '0);
		end

		foreach (directed_rows[r])
			send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
				directed_rows[r].typed, directed_rows[r].want);

		// fresh random taps, one rebuild of the chain
		for (k = 0; k < TAPS; k++)
			send_item(fcf_pkg::CMD_LOAD, k[fcf_pkg::IDX_W-1:0], pick_value(), 1'b0, '0);

		// random stream: mostly samples, occasional tap reloads
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_odds = 0;
					1: idle_odds = 3;
					default: idle_odds = 6;
				endcase
			end
			if (k >= RANDOM_ITEMS - QUIET_TAIL)
				idle_odds = 0;
			if ($urandom_range(0, 15) == 0) begin
				op = fcf_pkg::CMD_LOAD;
				if ($urandom_range(0, 7) == 0)
					pick = $urandom_range(TAPS, 511);
				else
					pick = $urandom_range(0, TAPS - 1);
			end else begin
				op = fcf_pkg::CMD_SAMPLE;
				pick = $urandom_range(0, 511);
			end
			idx = pick[fcf_pkg::IDX_W-1:0];
			send_item(op, idx, pick_value(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		// drain
		while (expected_filtered.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_filtered.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/fcf_pkg.sv
rtl/core/fcf_cell.sv
rtl/core/fcf_head.sv
rtl/core/fir_convolution_filter_core.sv
rtl/core/fcf_checker.sv
tb/tb_fir_convolution_filter_core.sv
